// File: rtl/daltp_pkg.sv
// daltp_pkg: shared types and constants for the dual-axis light tracker
// holds the microcode word, the control program and the register index codes
// no dependencies
package daltp_pkg;

    localparam int GAIN_W     = 24;
    localparam int ALPHA_W    = 17;
    localparam int INTEG_W    = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;
    localparam int STEPS_W    = 16;
    localparam int ALPHA_SHIFT = 16;
    localparam logic [ALPHA_W-1:0] ALPHA_ONE = 17'd65536;
    localparam int PC_W = 4;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ALPHA    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_AZ_PROP  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_AZ_INTEG = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_AZ_DERIV = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_EL_PROP  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_EL_INTEG = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_EL_DERIV = 3'd6;

    // sensor channel order
    localparam logic [1:0] CH_NORTH = 2'd0;
    localparam logic [1:0] CH_WEST  = 2'd1;
    localparam logic [1:0] CH_EAST  = 2'd2;
    localparam logic [1:0] CH_SOUTH = 2'd3;

    // program steps
    localparam logic [PC_W-1:0] STEP_EMA0   = 4'd0;
    localparam logic [PC_W-1:0] STEP_EMA1   = 4'd1;
    localparam logic [PC_W-1:0] STEP_EMA2   = 4'd2;
    localparam logic [PC_W-1:0] STEP_EMA3   = 4'd3;
    localparam logic [PC_W-1:0] STEP_WB3    = 4'd4;
    localparam logic [PC_W-1:0] STEP_ERR    = 4'd5;
    localparam logic [PC_W-1:0] STEP_AZ_P   = 4'd6;
    localparam logic [PC_W-1:0] STEP_AZ_I   = 4'd7;
    localparam logic [PC_W-1:0] STEP_AZ_D   = 4'd8;
    localparam logic [PC_W-1:0] STEP_EL_P   = 4'd9;
    localparam logic [PC_W-1:0] STEP_EL_I   = 4'd10;
    localparam logic [PC_W-1:0] STEP_EL_D   = 4'd11;
    localparam logic [PC_W-1:0] STEP_EL_SUM = 4'd12;
    localparam logic [PC_W-1:0] STEP_DONE   = 4'd13;
    localparam logic [PC_W-1:0] STEP_LOAD   = 4'd14;

    typedef enum logic [2:0] {
        MUL_NONE,
        MUL_EMA,
        MUL_AZ_P,
        MUL_AZ_I,
        MUL_AZ_D,
        MUL_EL_P,
        MUL_EL_I,
        MUL_EL_D
    } t_mul_op;

    typedef enum logic [1:0] {
        ACC_HOLD,
        ACC_LOAD,
        ACC_ADD
    } t_acc_op;

    typedef enum logic [1:0] {
        JMP_NONE,
        JMP_UNPRIMED,
        JMP_ALWAYS
    } t_jmp;

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } t_seq_state;

    typedef struct packed {
        t_mul_op         mul_op;
        logic [1:0]      ch_mul;
        logic            ema_wr;
        logic [1:0]      ch_wr;
        logic            load_all;
        logic            err_upd;
        t_acc_op         acc_op;
        logic            hold_az;
        logic            prev_upd;
        logic            done;
        t_jmp            jmp;
        logic [PC_W-1:0] target;
    } t_ucode;

    typedef struct packed {
        logic   accept;
        logic   step_en;
        t_ucode uc;
    } t_dp_ctl;

    // control program: one word per step
    function automatic t_ucode ucode(input logic [PC_W-1:0] pc);
        t_ucode uc;
        uc = '0;
        case (pc)
            STEP_EMA0: begin
                uc.mul_op = MUL_EMA;  uc.ch_mul = CH_NORTH;
                uc.jmp = JMP_UNPRIMED; uc.target = STEP_LOAD;
            end
            STEP_EMA1: begin
                uc.mul_op = MUL_EMA;  uc.ch_mul = CH_WEST;
                uc.ema_wr = 1'b1;     uc.ch_wr = CH_NORTH;
            end
            STEP_EMA2: begin
                uc.mul_op = MUL_EMA;  uc.ch_mul = CH_EAST;
                uc.ema_wr = 1'b1;     uc.ch_wr = CH_WEST;
            end
            STEP_EMA3: begin
                uc.mul_op = MUL_EMA;  uc.ch_mul = CH_SOUTH;
                uc.ema_wr = 1'b1;     uc.ch_wr = CH_EAST;
            end
            STEP_WB3: begin
                uc.ema_wr = 1'b1;     uc.ch_wr = CH_SOUTH;
            end
            STEP_ERR: begin
                uc.err_upd = 1'b1;
            end
            STEP_AZ_P: begin
                uc.mul_op = MUL_AZ_P;
            end
            STEP_AZ_I: begin
                uc.mul_op = MUL_AZ_I; uc.acc_op = ACC_LOAD;
            end
            STEP_AZ_D: begin
                uc.mul_op = MUL_AZ_D; uc.acc_op = ACC_ADD;
            end
            STEP_EL_P: begin
                uc.mul_op = MUL_EL_P; uc.acc_op = ACC_ADD;
            end
            STEP_EL_I: begin
                uc.mul_op = MUL_EL_I; uc.acc_op = ACC_LOAD;
                uc.hold_az = 1'b1;
            end
            STEP_EL_D: begin
                uc.mul_op = MUL_EL_D; uc.acc_op = ACC_ADD;
            end
            STEP_EL_SUM: begin
                uc.acc_op = ACC_ADD;  uc.prev_upd = 1'b1;
            end
            STEP_DONE: begin
                uc.done = 1'b1;
            end
            STEP_LOAD: begin
                uc.load_all = 1'b1;
                uc.jmp = JMP_ALWAYS;  uc.target = STEP_ERR;
            end
            default: begin
                uc.done = 1'b1;
            end
        endcase
        return uc;
    endfunction

endpackage

// File: rtl/daltp_datapath.sv
// daltp_datapath: sample filters, error and integral registers, shared multiplier,
// accumulator and result register of the light tracker, driven by one control word
// depends on daltp_pkg
module daltp_datapath #(
    parameter int SAMPLE_BITS   = 12,
    parameter int FRACTION_BITS = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  daltp_pkg::t_dp_ctl                    i_ctl,
    input  logic [SAMPLE_BITS-1:0]                i_light_north,
    input  logic [SAMPLE_BITS-1:0]                i_light_west,
    input  logic [SAMPLE_BITS-1:0]                i_light_east,
    input  logic [SAMPLE_BITS-1:0]                i_light_south,
    input  logic                                  i_az_queue_has_space,
    input  logic                                  i_el_queue_has_space,
    input  logic [daltp_pkg::ALPHA_W-1:0]         i_alpha,
    input  logic signed [daltp_pkg::GAIN_W-1:0]   i_az_kp,
    input  logic signed [daltp_pkg::GAIN_W-1:0]   i_az_ki,
    input  logic signed [daltp_pkg::GAIN_W-1:0]   i_az_kd,
    input  logic signed [daltp_pkg::GAIN_W-1:0]   i_el_kp,
    input  logic signed [daltp_pkg::GAIN_W-1:0]   i_el_ki,
    input  logic signed [daltp_pkg::GAIN_W-1:0]   i_el_kd,
    output logic                                  o_primed,
    output logic signed [daltp_pkg::STEPS_W-1:0]  o_az_steps,
    output logic signed [daltp_pkg::STEPS_W-1:0]  o_el_steps,
    output logic                                  o_az_command_valid,
    output logic                                  o_el_command_valid,
    output logic signed [SAMPLE_BITS:0]           o_az_error_out,
    output logic signed [SAMPLE_BITS:0]           o_el_error_out
);
    import daltp_pkg::*;

    localparam int LVL_W = SAMPLE_BITS + FRACTION_BITS;
    localparam int ERR_W = SAMPLE_BITS + 1;
    localparam int DE_W  = SAMPLE_BITS + 2;
    localparam int MA_W  = (LVL_W + 1 > INTEG_W) ? LVL_W + 1 : INTEG_W;
    localparam int MB_W  = GAIN_W;
    localparam int P_W   = MA_W + MB_W;
    localparam int ACC_W = P_W + 2;
    localparam logic signed [ACC_W:0] FRAC_MASK =
        {{(ACC_W + 1 - FRACTION_BITS){1'b0}}, {FRACTION_BITS{1'b1}}};

    t_ucode uc;

    logic [SAMPLE_BITS-1:0]    r_sample [4];
    logic                      r_az_space;
    logic                      r_el_space;
    logic [LVL_W-1:0]          r_level [4];
    logic [LVL_W-1:0]          r_s_sel;
    logic signed [P_W-1:0]     r_prod;
    logic signed [ACC_W-1:0]   r_acc;
    logic signed [ERR_W-1:0]   r_e_az;
    logic signed [ERR_W-1:0]   r_e_el;
    logic signed [ERR_W-1:0]   r_prev_az;
    logic signed [ERR_W-1:0]   r_prev_el;
    logic signed [INTEG_W-1:0] r_integ_az;
    logic signed [INTEG_W-1:0] r_integ_el;
    logic signed [STEPS_W-1:0] r_az_hold;
    logic                      r_primed;

    logic signed [STEPS_W-1:0] r_az_steps;
    logic signed [STEPS_W-1:0] r_el_steps;
    logic                      r_az_cmd;
    logic                      r_el_cmd;
    logic signed [ERR_W-1:0]   r_az_err;
    logic signed [ERR_W-1:0]   r_el_err;

    logic [ALPHA_W-1:0]        alpha_eff;
    logic [LVL_W-1:0]          x_sel;
    logic [LVL_W-1:0]          s_sel;
    logic signed [LVL_W:0]     ema_diff;
    logic signed [P_W-1:0]     ema_sum;
    logic [LVL_W-1:0]          s_new;
    logic signed [ERR_W-1:0]   e_az_c;
    logic signed [ERR_W-1:0]   e_el_c;
    logic signed [DE_W-1:0]    de_az;
    logic signed [DE_W-1:0]    de_el;
    logic signed [MA_W-1:0]    mul_a;
    logic signed [MB_W-1:0]    mul_b;
    logic signed [ACC_W:0]     acc_x;
    logic signed [ACC_W:0]     q;
    logic signed [ACC_W:0]     q_neg;
    logic signed [STEPS_W-1:0] az_sat;
    logic signed [STEPS_W-1:0] el_sat;

    function automatic logic signed [INTEG_W-1:0] sat_integ(
        input logic signed [INTEG_W-1:0] acc,
        input logic signed [ERR_W-1:0]   e
    );
        logic signed [INTEG_W:0] sum;
        sum = (INTEG_W + 1)'(acc) + (INTEG_W + 1)'(e);
        if (sum[INTEG_W] != sum[INTEG_W-1]) begin
            return sum[INTEG_W] ? {1'b1, {(INTEG_W - 1){1'b0}}}
                                : {1'b0, {(INTEG_W - 1){1'b1}}};
        end
        return sum[INTEG_W-1:0];
    endfunction

    function automatic logic signed [STEPS_W-1:0] sat_steps(
        input logic signed [ACC_W:0] v
    );
        logic signed [ACC_W:0] hi;
        logic signed [ACC_W:0] lo;
        hi = (ACC_W + 1)'(32767);
        lo = -(ACC_W + 1)'(32768);
        if (v > hi) begin
            return 16'sh7FFF;
        end
        if (v < lo) begin
            return 16'sh8000;
        end
        return v[STEPS_W-1:0];
    endfunction

    assign uc = i_ctl.uc;

    always_comb begin
        alpha_eff = (i_alpha > ALPHA_ONE) ? ALPHA_ONE : i_alpha;
        x_sel     = {r_sample[uc.ch_mul], {FRACTION_BITS{1'b0}}};
        s_sel     = r_level[uc.ch_mul];
        ema_diff  = $signed({1'b0, x_sel}) - $signed({1'b0, s_sel});
        // floor of the weighted step, added onto the old level
        ema_sum   = $signed({{(P_W - LVL_W){1'b0}}, r_s_sel}) + (r_prod >>> ALPHA_SHIFT);
        s_new     = ema_sum[LVL_W-1:0];

        e_az_c = $signed({1'b0, r_level[CH_EAST][LVL_W-1:FRACTION_BITS]})
               - $signed({1'b0, r_level[CH_WEST][LVL_W-1:FRACTION_BITS]});
        e_el_c = $signed({1'b0, r_level[CH_NORTH][LVL_W-1:FRACTION_BITS]})
               - $signed({1'b0, r_level[CH_SOUTH][LVL_W-1:FRACTION_BITS]});
        de_az  = DE_W'(r_e_az) - DE_W'(r_prev_az);
        de_el  = DE_W'(r_e_el) - DE_W'(r_prev_el);

        case (uc.mul_op)
            MUL_EMA: begin
                mul_a = MA_W'(ema_diff);
                mul_b = $signed(MB_W'(alpha_eff));
            end
            MUL_AZ_P: begin
                mul_a = MA_W'(r_e_az);
                mul_b = i_az_kp;
            end
            MUL_AZ_I: begin
                mul_a = MA_W'(r_integ_az);
                mul_b = i_az_ki;
            end
            MUL_AZ_D: begin
                mul_a = MA_W'(de_az);
                mul_b = i_az_kd;
            end
            MUL_EL_P: begin
                mul_a = MA_W'(r_e_el);
                mul_b = i_el_kp;
            end
            MUL_EL_I: begin
                mul_a = MA_W'(r_integ_el);
                mul_b = i_el_ki;
            end
            MUL_EL_D: begin
                mul_a = MA_W'(de_el);
                mul_b = i_el_kd;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase

        // truncate toward zero: bias negative sums before the shift
        acc_x  = (ACC_W + 1)'(r_acc) + (r_acc[ACC_W-1] ? FRAC_MASK : '0);
        q      = acc_x >>> FRACTION_BITS;
        q_neg  = -q;
        az_sat = sat_steps(q);
        el_sat = sat_steps(q_neg);
    end

    // loop state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_primed   <= 1'b0;
            r_integ_az <= '0;
            r_integ_el <= '0;
            r_prev_az  <= '0;
            r_prev_el  <= '0;
        end else if (i_ctl.step_en) begin
            if (uc.load_all) begin
                r_primed <= 1'b1;
            end
            if (uc.err_upd) begin
                if (r_az_space) begin
                    r_integ_az <= sat_integ(r_integ_az, e_az_c);
                end
                if (r_el_space) begin
                    r_integ_el <= sat_integ(r_integ_el, e_el_c);
                end
            end
            if (uc.prev_upd) begin
                r_prev_az <= r_e_az;
                r_prev_el <= r_e_el;
            end
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        if (i_ctl.accept) begin
            r_sample[CH_NORTH] <= i_light_north;
            r_sample[CH_WEST]  <= i_light_west;
            r_sample[CH_EAST]  <= i_light_east;
            r_sample[CH_SOUTH] <= i_light_south;
            r_az_space         <= i_az_queue_has_space;
            r_el_space         <= i_el_queue_has_space;
        end
        if (i_ctl.step_en) begin
            if (uc.mul_op != MUL_NONE) begin
                r_prod <= mul_a * mul_b;
            end
            if (uc.mul_op == MUL_EMA) begin
                r_s_sel <= s_sel;
            end
            if (uc.load_all) begin
                for (int i = 0; i < 4; i++) begin
                    r_level[i] <= {r_sample[i], {FRACTION_BITS{1'b0}}};
                end
            end else if (uc.ema_wr) begin
                r_level[uc.ch_wr] <= s_new;
            end
            if (uc.err_upd) begin
                r_e_az <= e_az_c;
                r_e_el <= e_el_c;
            end
            case (uc.acc_op)
                ACC_LOAD: r_acc <= ACC_W'(r_prod);
                ACC_ADD:  r_acc <= r_acc + ACC_W'(r_prod);
                default:  r_acc <= r_acc;
            endcase
            if (uc.hold_az) begin
                r_az_hold <= az_sat;
            end
            if (uc.done) begin
                r_az_steps <= r_az_hold;
                r_el_steps <= el_sat;
                r_az_cmd   <= (r_az_hold != '0);
                r_el_cmd   <= (el_sat != '0);
                r_az_err   <= r_e_az;
                r_el_err   <= r_e_el;
            end
        end
    end

    assign o_primed           = r_primed;
    assign o_az_steps         = r_az_steps;
    assign o_el_steps         = r_el_steps;
    assign o_az_command_valid = r_az_cmd;
    assign o_el_command_valid = r_el_cmd;
    assign o_az_error_out     = r_az_err;
    assign o_el_error_out     = r_el_err;

endmodule

// File: rtl/daltp_sequencer.sv
// daltp_sequencer: step counter, program lookup and channel handshakes
// holds the result valid flag; depends on daltp_pkg
module daltp_sequencer (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    output logic               o_valid,
    input  logic               i_ready,
    input  logic               i_primed,
    output daltp_pkg::t_dp_ctl o_ctl
);
    import daltp_pkg::*;

    t_seq_state      r_state;
    t_seq_state      n_state;
    logic [PC_W-1:0] r_pc;
    logic [PC_W-1:0] n_pc;
    logic            r_out_valid;
    logic            n_out_valid;
    t_ucode          uc;
    logic            accept;
    logic            stall;
    logic            step_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_pc        <= STEP_EMA0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_pc        <= n_pc;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        uc      = ucode(r_pc);
        accept  = (r_state == ST_IDLE) && i_valid;
        // the final step waits until the result register is free
        stall   = uc.done && r_out_valid && !i_ready;
        step_en = (r_state == ST_RUN) && !stall;
        n_state = r_state;
        n_pc    = r_pc;
        case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    n_state = ST_RUN;
                    n_pc    = STEP_EMA0;
                end
            end
            ST_RUN: begin
                if (step_en) begin
                    if (uc.done) begin
                        n_state = ST_IDLE;
                        n_pc    = STEP_EMA0;
                    end else if (uc.jmp == JMP_ALWAYS
                                 || (uc.jmp == JMP_UNPRIMED && !i_primed)) begin
                        n_pc = uc.target;
                    end else begin
                        n_pc = r_pc + 1'b1;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
                n_pc    = STEP_EMA0;
            end
        endcase
        n_out_valid = (r_out_valid && !i_ready) || (step_en && uc.done);
    end

    assign o_ready       = (r_state == ST_IDLE);
    assign o_valid       = r_out_valid;
    assign o_ctl.accept  = accept;
    assign o_ctl.step_en = step_en;
    assign o_ctl.uc      = uc;

    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state == ST_RUN) && (r_pc == STEP_EMA0))
        else $error("transfer in did not start the program at its first step");

    a_done_sets_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (step_en && uc.done) |=> r_out_valid && (r_state == ST_IDLE))
        else $error("finished program did not present a result");

    a_pc_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RUN) |-> (r_pc <= STEP_LOAD))
        else $error("step counter left the program");

    a_stall_only_at_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ST_RUN) && !step_en) |-> (uc.done && r_out_valid))
        else $error("program stalled away from its final step");

endmodule

// File: rtl/dual_axis_light_tracker_pid.sv
// dual_axis_light_tracker_pid: top level with configuration registers
// instantiates daltp_sequencer and daltp_datapath; depends on daltp_pkg
//
// usage:
//   input channel i_valid / o_ready carries one set of four light samples and two
//   queue-space flags; output channel o_valid / i_ready carries the step commands,
//   their nonzero flags and the filtered errors. one result per input transfer.
//   configuration is a plain write port (i_cfg_we, i_cfg_index, i_cfg_data), taken
//   on any edge with i_cfg_we high; index 0 is alpha, 1..6 the azimuth and
//   elevation gains (p, i, d); other indexes are ignored. write only while idle.
//   timing: a small program runs on one shared multiplier, one step per cycle
//   unless parked at its final step. o_ready rises together with o_valid, and
//   no new item is taken until the program of the last one has finished, so the
//   rate is set by the program length on the single multiplier.
//   a result waits in the output register while the next item is accepted and
//   worked on; if the receiver still holds off, the program parks at its final
//   step until the register is taken.
//   reset clears the filters' primed flag, integrals, previous errors and the
//   result flag, and restores the register defaults.
module dual_axis_light_tracker_pid #(
    parameter int SAMPLE_BITS   = 12,
    parameter int FRACTION_BITS = 16
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_valid,
    output logic                                    o_ready,
    input  logic [SAMPLE_BITS-1:0]                  i_light_north,
    input  logic [SAMPLE_BITS-1:0]                  i_light_west,
    input  logic [SAMPLE_BITS-1:0]                  i_light_east,
    input  logic [SAMPLE_BITS-1:0]                  i_light_south,
    input  logic                                    i_az_queue_has_space,
    input  logic                                    i_el_queue_has_space,
    output logic                                    o_valid,
    input  logic                                    i_ready,
    output logic signed [daltp_pkg::STEPS_W-1:0]    o_az_steps,
    output logic signed [daltp_pkg::STEPS_W-1:0]    o_el_steps,
    output logic                                    o_az_command_valid,
    output logic                                    o_el_command_valid,
    output logic signed [SAMPLE_BITS:0]             o_az_error_out,
    output logic signed [SAMPLE_BITS:0]             o_el_error_out,
    input  logic                                    i_cfg_we,
    input  logic [daltp_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [daltp_pkg::CFG_DATA_W-1:0]        i_cfg_data
);
    import daltp_pkg::*;

    logic [ALPHA_W-1:0]       r_alpha;
    logic signed [GAIN_W-1:0] r_az_kp;
    logic signed [GAIN_W-1:0] r_az_ki;
    logic signed [GAIN_W-1:0] r_az_kd;
    logic signed [GAIN_W-1:0] r_el_kp;
    logic signed [GAIN_W-1:0] r_el_ki;
    logic signed [GAIN_W-1:0] r_el_kd;

    t_dp_ctl ctl;
    logic    primed;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alpha <= 17'd6554;
            r_az_kp <= 24'sd6554;
            r_az_ki <= '0;
            r_az_kd <= '0;
            r_el_kp <= 24'sd6554;
            r_el_ki <= '0;
            r_el_kd <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_ALPHA:    r_alpha <= i_cfg_data[ALPHA_W-1:0];
                REG_AZ_PROP:  r_az_kp <= $signed(i_cfg_data[GAIN_W-1:0]);
                REG_AZ_INTEG: r_az_ki <= $signed(i_cfg_data[GAIN_W-1:0]);
                REG_AZ_DERIV: r_az_kd <= $signed(i_cfg_data[GAIN_W-1:0]);
                REG_EL_PROP:  r_el_kp <= $signed(i_cfg_data[GAIN_W-1:0]);
                REG_EL_INTEG: r_el_ki <= $signed(i_cfg_data[GAIN_W-1:0]);
                REG_EL_DERIV: r_el_kd <= $signed(i_cfg_data[GAIN_W-1:0]);
                default: ;
            endcase
        end
    end

    daltp_sequencer u_seq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .o_valid  (o_valid),
        .i_ready  (i_ready),
        .i_primed (primed),
        .o_ctl    (ctl)
    );

    daltp_datapath #(
        .SAMPLE_BITS   (SAMPLE_BITS),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_dp (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_ctl                (ctl),
        .i_light_north        (i_light_north),
        .i_light_west         (i_light_west),
        .i_light_east         (i_light_east),
        .i_light_south        (i_light_south),
        .i_az_queue_has_space (i_az_queue_has_space),
        .i_el_queue_has_space (i_el_queue_has_space),
        .i_alpha              (r_alpha),
        .i_az_kp              (r_az_kp),
        .i_az_ki              (r_az_ki),
        .i_az_kd              (r_az_kd),
        .i_el_kp              (r_el_kp),
        .i_el_ki              (r_el_ki),
        .i_el_kd              (r_el_kd),
        .o_primed             (primed),
        .o_az_steps           (o_az_steps),
        .o_el_steps           (o_el_steps),
        .o_az_command_valid   (o_az_command_valid),
        .o_el_command_valid   (o_el_command_valid),
        .o_az_error_out       (o_az_error_out),
        .o_el_error_out       (o_el_error_out)
    );

endmodule

// File: test/testbench.sv
// testbench for dual_axis_light_tracker_pid: sensor sets in, pid step commands out
// predicts each result from its own model of the filters and loops; needs daltp_pkg
`timescale 1ns / 1ps

module testbench;
    import daltp_pkg::*;

    localparam int SAMPLE_BITS   = 12;
    localparam int FRACTION_BITS = 16;
    localparam int SAMPLE_MAX    = (1 << SAMPLE_BITS) - 1;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
    localparam longint INTEG_MAX = 64'sd2147483647;
    localparam longint INTEG_MIN = -64'sd2147483648;
    localparam int ITEMS_PER_PHASE = 300;
    localparam int RANDOM_PHASES   = 6;

    typedef struct packed {
        logic [SAMPLE_BITS-1:0] north;
        logic [SAMPLE_BITS-1:0] west;
        logic [SAMPLE_BITS-1:0] east;
        logic [SAMPLE_BITS-1:0] south;
        logic                   az_space;
        logic                   el_space;
    } t_sample_set;

    typedef struct packed {
        logic signed [STEPS_W-1:0]   az_steps;
        logic signed [STEPS_W-1:0]   el_steps;
        logic                        az_cmd;
        logic                        el_cmd;
        logic signed [SAMPLE_BITS:0] az_err;
        logic signed [SAMPLE_BITS:0] el_err;
    } t_step_command;

    logic                            i_clk = 1'b0;
    logic                            i_rst_n = 1'b0;
    logic                            i_valid = 1'b0;
    logic                            o_ready;
    logic [SAMPLE_BITS-1:0]          i_light_north = '0;
    logic [SAMPLE_BITS-1:0]          i_light_west = '0;
    logic [SAMPLE_BITS-1:0]          i_light_east = '0;
    logic [SAMPLE_BITS-1:0]          i_light_south = '0;
    logic                            i_az_queue_has_space = 1'b0;
    logic                            i_el_queue_has_space = 1'b0;
    logic                            o_valid;
    logic                            i_ready = 1'b0;
    logic signed [STEPS_W-1:0]       o_az_steps;
    logic signed [STEPS_W-1:0]       o_el_steps;
    logic                            o_az_command_valid;
    logic                            o_el_command_valid;
    logic signed [SAMPLE_BITS:0]     o_az_error_out;
    logic signed [SAMPLE_BITS:0]     o_el_error_out;
    logic                            i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]            i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]           i_cfg_data = '0;

    dual_axis_light_tracker_pid #(
        .SAMPLE_BITS  (SAMPLE_BITS),
        .FRACTION_BITS(FRACTION_BITS)
    ) dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_valid             (i_valid),
        .o_ready             (o_ready),
        .i_light_north       (i_light_north),
        .i_light_west        (i_light_west),
        .i_light_east        (i_light_east),
        .i_light_south       (i_light_south),
        .i_az_queue_has_space(i_az_queue_has_space),
        .i_el_queue_has_space(i_el_queue_has_space),
        .o_valid             (o_valid),
        .i_ready             (i_ready),
        .o_az_steps          (o_az_steps),
        .o_el_steps          (o_el_steps),
        .o_az_command_valid  (o_az_command_valid),
        .o_el_command_valid  (o_el_command_valid),
        .o_az_error_out      (o_az_error_out),
        .o_el_error_out      (o_el_error_out),
        .i_cfg_we            (i_cfg_we),
        .i_cfg_index         (i_cfg_index),
        .i_cfg_data          (i_cfg_data)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // tracker model state, reset values
    logic [31:0]        ema_level [0:3] = '{default: '0};
    bit                 primed = 1'b0;
    int                 az_integral = 0;
    int                 el_integral = 0;
    int                 az_prev_err = 0;
    int                 el_prev_err = 0;
    logic [ALPHA_W-1:0] alpha_reg = 17'd6554;
    int                 az_kp = 6554;
    int                 az_ki = 0;
    int                 az_kd = 0;
    int                 el_kp = 6554;
    int                 el_ki = 0;
    int                 el_kd = 0;

    t_step_command pending_commands [$];
    int            mismatch_count = 0;
    int            burst_left = 0;
    int            ready_run = 0;

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $time, msg);
        mismatch_count++;
    endtask

    function automatic longint clamp_steps(input longint v);
        if (v > 32767)
            return 32767;
        if (v < -32768)
            return -32768;
        return v;
    endfunction

    function automatic longint pid_axis(input int e, inout int integ, inout int prev,
                                        input bit space, input int kp, input int ki,
                                        input int kd);
        longint sum;
        longint u;
        if (space) begin
            sum = longint'(integ) + e;
            if (sum > INTEG_MAX)
                integ = int'(INTEG_MAX);
            else if (sum < INTEG_MIN)
                integ = int'(INTEG_MIN);
            else
                integ = int'(sum);
        end
        u = longint'(kp) * e + longint'(ki) * integ + longint'(kd) * (longint'(e) - prev);
        prev = e;
        // truncate toward zero
        if (u < 0)
            return -((-u) >> FRACTION_BITS);
        return u >> FRACTION_BITS;
    endfunction

    function automatic t_step_command track_light_step(input t_sample_set s);
        logic [SAMPLE_BITS-1:0] raw [0:3];
        longint                 a;
        longint                 x;
        int                     lvl [0:3];
        int                     e_az;
        int                     e_el;
        longint                 az;
        longint                 el;
        t_step_command          r;
        raw[0] = s.north;
        raw[1] = s.west;
        raw[2] = s.east;
        raw[3] = s.south;
        a = (alpha_reg > ALPHA_ONE) ? longint'(ALPHA_ONE) : longint'(alpha_reg);
        for (int i = 0; i < 4; i++) begin
            x = longint'(raw[i]) << FRACTION_BITS;
            if (!primed)
                ema_level[i] = x[31:0];
            else
                ema_level[i] = 32'((longint'(ema_level[i]) * (longint'(ALPHA_ONE) - a)
                                    + x * a) >> ALPHA_SHIFT);
            lvl[i] = int'(ema_level[i] >> FRACTION_BITS);
        end
        primed = 1'b1;
        e_az = lvl[2] - lvl[1];
        e_el = lvl[0] - lvl[3];
        az = clamp_steps(pid_axis(e_az, az_integral, az_prev_err, s.az_space,
                                  az_kp, az_ki, az_kd));
        el = clamp_steps(-pid_axis(e_el, el_integral, el_prev_err, s.el_space,
                                   el_kp, el_ki, el_kd));
        r.az_steps = az[STEPS_W-1:0];
        r.el_steps = el[STEPS_W-1:0];
        r.az_cmd   = (az != 0);
        r.el_cmd   = (el != 0);
        r.az_err   = e_az[SAMPLE_BITS:0];
        r.el_err   = e_el[SAMPLE_BITS:0];
        return r;
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            REG_ALPHA:    alpha_reg = data[ALPHA_W-1:0];
            REG_AZ_PROP:  az_kp = {{8{data[23]}}, data};
            REG_AZ_INTEG: az_ki = {{8{data[23]}}, data};
            REG_AZ_DERIV: az_kd = {{8{data[23]}}, data};
            REG_EL_PROP:  el_kp = {{8{data[23]}}, data};
            REG_EL_INTEG: el_ki = {{8{data[23]}}, data};
            REG_EL_DERIV: el_kd = {{8{data[23]}}, data};
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    task automatic load_gains(input logic [23:0] alpha, input logic [23:0] azp,
                              input logic [23:0] azi, input logic [23:0] azd,
                              input logic [23:0] elp, input logic [23:0] eli,
                              input logic [23:0] eld);
        write_reg(REG_ALPHA, alpha);
        write_reg(REG_AZ_PROP, azp);
        write_reg(REG_AZ_INTEG, azi);
        write_reg(REG_AZ_DERIV, azd);
        write_reg(REG_EL_PROP, elp);
        write_reg(REG_EL_INTEG, eli);
        write_reg(REG_EL_DERIV, eld);
    endtask

    // valid stays high after the transfer; only a gap or a drain lowers it
    task automatic send_set(input t_sample_set s);
        i_valid              <= 1'b1;
        i_light_north        <= s.north;
        i_light_west         <= s.west;
        i_light_east         <= s.east;
        i_light_south        <= s.south;
        i_az_queue_has_space <= s.az_space;
        i_el_queue_has_space <= s.el_space;
        @(posedge i_clk);
        while (!o_ready)
            @(posedge i_clk);
        pending_commands.push_back(track_light_step(s));
    endtask

    task automatic wait_idle();
        i_valid <= 1'b0;
        while (pending_commands.size() != 0)
            @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    // receiver: long ready stretches, short ready bursts and stalls of random length
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready   <= 1'b0;
            ready_run <= 0;
        end else if (ready_run != 0) begin
            ready_run <= ready_run - 1;
        end else begin
            case ($urandom_range(0, 5))
                0: begin
                    i_ready   <= 1'b1;
                    ready_run <= $urandom_range(40, 120);
                end
                1, 2: begin
                    i_ready   <= 1'b0;
                    ready_run <= $urandom_range(0, 15);
                end
                default: begin
                    i_ready   <= 1'b1;
                    ready_run <= $urandom_range(0, 6);
                end
            endcase
        end
    end

    task automatic check_field(input string name, input logic [15:0] got,
                               input logic [15:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %h expected %h", name, got, want));
    endtask

    always @(posedge i_clk) begin
        t_step_command want;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_commands.size() == 0) begin
                report_mismatch("result transfer with nothing pending");
            end else begin
                want = pending_commands.pop_front();
                check_field("az_steps", o_az_steps, want.az_steps);
                check_field("el_steps", o_el_steps, want.el_steps);
                check_field("az_command_valid", 16'(o_az_command_valid), 16'(want.az_cmd));
                check_field("el_command_valid", 16'(o_el_command_valid), 16'(want.el_cmd));
                check_field("az_error_out", 16'(o_az_error_out), 16'(want.az_err));
                check_field("el_error_out", 16'(o_el_error_out), 16'(want.el_err));
            end
        end
    end

    function automatic logic [23:0] random_gain();
        case ($urandom_range(0, 5))
            0:       return 24'h7FFFFF;
            1:       return 24'h800000;
            2:       return 24'h000000;
            3:       return 24'($urandom_range(0, 8 << FRACTION_BITS) - (4 << FRACTION_BITS));
            4:       return 24'($urandom);
            default: return 24'($urandom_range(0, 16383) - 8192);
        endcase
    endfunction

    function automatic logic [23:0] random_alpha();
        case ($urandom_range(0, 5))
            0:       return 24'd0;
            1:       return 24'd65536;
            2:       return 24'($urandom_range(65537, 131071));
            3:       return 24'($urandom);
            default: return 24'($urandom_range(1, 65535));
        endcase
    endfunction

    function automatic logic [SAMPLE_BITS-1:0] near_level(input int base);
        int v;
        v = base + int'($urandom_range(0, 64)) - 32;
        if (v < 0)
            v = 0;
        if (v > SAMPLE_MAX)
            v = SAMPLE_MAX;
        return v[SAMPLE_BITS-1:0];
    endfunction

    // first item loads the filters; nonzero d gains see the full first error
    task automatic test_first_item_load();
        write_reg(REG_AZ_DERIV, 24'h030000);
        write_reg(REG_EL_DERIV, 24'hFE0000);
        send_set('{north: 12'hFFF, west: 12'h000, east: 12'hFFF, south: 12'h000,
                   az_space: 1'b1, el_space: 1'b1});
        send_set('{north: 12'h000, west: 12'hFFF, east: 12'h000, south: 12'hFFF,
                   az_space: 1'b1, el_space: 1'b0});
        send_set('{north: 12'h000, west: 12'h000, east: 12'h000, south: 12'h000,
                   az_space: 1'b0, el_space: 1'b1});
        send_set('{north: 12'hFFF, west: 12'hFFF, east: 12'hFFF, south: 12'hFFF,
                   az_space: 1'b1, el_space: 1'b1});
        wait_idle();
    endtask

    // alpha of zero holds, one tracks, above one acts as one
    task automatic test_alpha_extremes();
        write_reg(REG_ALPHA, 24'd0);
        send_set('{12'h000, 12'hFFF, 12'h800, 12'h001, 1'b1, 1'b1});
        send_set('{12'hFFF, 12'h000, 12'h7FF, 12'hFFE, 1'b0, 1'b0});
        wait_idle();
        write_reg(REG_ALPHA, 24'd65536);
        send_set('{12'h000, 12'hFFF, 12'h800, 12'h001, 1'b1, 1'b1});
        send_set('{12'hFFF, 12'h000, 12'h7FF, 12'hFFE, 1'b1, 1'b1});
        wait_idle();
        write_reg(REG_ALPHA, 24'hFFFFFF);
        send_set('{12'h123, 12'hABC, 12'hFFF, 12'h000, 1'b0, 1'b1});
        send_set('{12'hFFF, 12'h000, 12'h000, 12'hFFF, 1'b1, 1'b0});
        wait_idle();
        write_reg(REG_ALPHA, 24'd65537);
        send_set('{12'h555, 12'hAAA, 12'h5A5, 12'hA5A, 1'b1, 1'b1});
        wait_idle();
    endtask

    task automatic test_step_saturation();
        load_gains(24'd65536, 24'h7FFFFF, 24'h0, 24'h0, 24'h800000, 24'h0, 24'h0);
        send_set('{12'hFFF, 12'h000, 12'hFFF, 12'h000, 1'b0, 1'b0});
        send_set('{12'h000, 12'hFFF, 12'h000, 12'hFFF, 1'b0, 1'b0});
        send_set('{12'h064, 12'h064, 12'h064, 12'h064, 1'b0, 1'b0});
        wait_idle();
        load_gains(24'd65536, 24'h800000, 24'h0, 24'h0, 24'h7FFFFF, 24'h0, 24'h0);
        send_set('{12'hFFF, 12'h000, 12'hFFF, 12'h000, 1'b0, 1'b0});
        send_set('{12'h000, 12'hFFF, 12'h000, 12'hFFF, 1'b0, 1'b0});
        wait_idle();
    endtask

    // integral gains only, with the queue-space flags gating accumulation
    task automatic test_integral_gating();
        load_gains(24'd65536, 24'h0, 24'h7FFFFF, 24'h0, 24'h0, 24'h800000, 24'h0);
        send_set('{12'hFFF, 12'h000, 12'hFFF, 12'h000, 1'b1, 1'b1});
        send_set('{12'hFFF, 12'h000, 12'hFFF, 12'h000, 1'b0, 1'b1});
        send_set('{12'hFFF, 12'h000, 12'hFFF, 12'h000, 1'b1, 1'b0});
        send_set('{12'h000, 12'hFFF, 12'h000, 12'hFFF, 1'b0, 1'b0});
        send_set('{12'h000, 12'h000, 12'h001, 12'h001, 1'b1, 1'b1});
        wait_idle();
    endtask

    task automatic test_unknown_index();
        write_reg(REG_UNUSED, 24'hFFFFFF);
        send_set('{12'h321, 12'h123, 12'h456, 12'h654, 1'b1, 1'b1});
        send_set('{12'h000, 12'hFFF, 12'hFFF, 12'h000, 1'b1, 1'b1});
        wait_idle();
    endtask

    task automatic test_random_traffic();
        t_sample_set s;
        int          base;
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            load_gains(random_alpha(), random_gain(), random_gain(), random_gain(),
                       random_gain(), random_gain(), random_gain());
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                case ($urandom_range(0, 3))
                    0: begin
                        s.north = SAMPLE_BITS'($urandom);
                        s.west  = SAMPLE_BITS'($urandom);
                        s.east  = SAMPLE_BITS'($urandom);
                        s.south = SAMPLE_BITS'($urandom);
                    end
                    1: begin
                        s.north = $urandom_range(0, 1) ? SAMPLE_BITS'(SAMPLE_MAX) : '0;
                        s.west  = $urandom_range(0, 1) ? SAMPLE_BITS'(SAMPLE_MAX) : '0;
                        s.east  = $urandom_range(0, 1) ? SAMPLE_BITS'(SAMPLE_MAX) : '0;
                        s.south = $urandom_range(0, 1) ? SAMPLE_BITS'(SAMPLE_MAX) : '0;
                    end
                    default: begin
                        // nearly balanced sensors keep the errors small
                        base    = $urandom_range(0, SAMPLE_MAX);
                        s.north = near_level(base);
                        s.west  = near_level(base);
                        s.east  = near_level(base);
                        s.south = near_level(base);
                    end
                endcase
                s.az_space = ($urandom_range(0, 3) != 0);
                s.el_space = ($urandom_range(0, 3) != 0);
                if (burst_left == 0) begin
                    i_valid <= 1'b0;
                    repeat ($urandom_range(1, 12)) @(posedge i_clk);
                    burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(60, 150)
                                                             : $urandom_range(1, 24);
                end
                burst_left--;
                send_set(s);
            end
            wait_idle();
        end
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_first_item_load();
        test_alpha_extremes();
        test_step_saturation();
        test_integral_gating();
        test_unknown_index();
        test_random_traffic();
        wait_idle();
        repeat (30) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    initial begin
        #5_000_000;
        $display("TEST FAILED");
        $finish;
    end

endmodule
